// File: src/c420ds_pkg.sv
// Shared types and constants for the 4:2:0 chroma box downsampler.
package c420ds_pkg;

  localparam int unsigned PIX_W      = 8;   // one Y, Cb or Cr sample
  localparam int unsigned SUM_W      = 9;   // horizontal pair sum
  localparam int unsigned TOT_W      = 10;  // full 2x2 block sum
  localparam int unsigned CFG_DATA_W = 15;  // widest register (image_height)
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned WIDTH_W    = 13;
  localparam int unsigned HEIGHT_W   = 15;
  localparam int unsigned CCOL_W     = 11;
  localparam int unsigned CROW_W     = 13;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // How the second stage forms the chroma result of a pixel.
  typedef enum logic [2:0] {
    KIND_NONE,   // no block completed
    KIND_PASS,   // odd corner: single sample
    KIND_PAIR,   // last row of odd height: (pair + 1) >> 1
    KIND_VERT,   // last column of odd width: (column pair + 1) >> 1
    KIND_QUAD    // full 2x2 block: (sum + 2) >> 2
  } chroma_kind_t;

  typedef struct packed {
    logic [SUM_W-1:0] u;
    logic [SUM_W-1:0] v;
  } pair_sum_t;

endpackage

// File: src/chroma_420_box_downsampler_top.sv
// Top level of the 4:2:0 chroma box downsampler: counters, line store and output stage.

// Takes one Y/Cb/Cr pixel per clock in raster order while in_stall is low and
// gives one result per pixel: luma unchanged, plus a 4:2:0 chroma sample on each
// pixel that closes a chroma block (2x2 average, or pair/single average at odd
// right and bottom edges). Sustained rate is one pixel per cycle unless out_stall
// holds the pipeline; a result passes the registered read of the line store and
// the stage 1 registers, then the output register. The line store keeps one even
// row's pair sums (MAX_WIDTH/2 entries) and needs no clearing after reset. Any
// configuration write restarts the image at row 0, column 0; a zero size is
// taken as 1 and a size above MAX_WIDTH or MAX_HEIGHT as that maximum.
module chroma_420_box_downsampler_top #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 16384
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration
  input  logic                                  cfg_wr_en,
  input  logic [c420ds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [c420ds_pkg::CFG_DATA_W-1:0]     cfg_data,
  // pixel input
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [c420ds_pkg::PIX_W-1:0]          in_y_sample,
  input  logic [c420ds_pkg::PIX_W-1:0]          in_u_sample,
  input  logic [c420ds_pkg::PIX_W-1:0]          in_v_sample,
  // results
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [c420ds_pkg::PIX_W-1:0]          out_luma,
  output logic                                  out_chroma_valid,
  output logic [c420ds_pkg::PIX_W-1:0]          out_chroma_u,
  output logic [c420ds_pkg::PIX_W-1:0]          out_chroma_v,
  output logic [c420ds_pkg::CCOL_W-1:0]         out_chroma_col,
  output logic [c420ds_pkg::CROW_W-1:0]         out_chroma_row,
  output logic                                  out_end_of_image
);

  localparam int unsigned CW         = $clog2(MAX_WIDTH);
  localparam int unsigned RW         = $clog2(MAX_HEIGHT);
  localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
  localparam int unsigned LW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  // ---------------------------------------------------------------------------
  // Configuration: keep the clamped last column and last row indexes
  // ---------------------------------------------------------------------------
  logic [CW-1:0] last_col_idx_r, last_col_idx_nxt;
  logic [RW-1:0] last_row_idx_r, last_row_idx_nxt;
  logic [c420ds_pkg::WIDTH_W-1:0]  cfg_width;
  logic [c420ds_pkg::HEIGHT_W-1:0] cfg_height;

  assign cfg_width  = cfg_data[c420ds_pkg::WIDTH_W-1:0];
  assign cfg_height = cfg_data[c420ds_pkg::HEIGHT_W-1:0];

  always_comb begin
    last_col_idx_nxt = last_col_idx_r;
    last_row_idx_nxt = last_row_idx_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        c420ds_pkg::REG_IMAGE_WIDTH: begin
          if (cfg_width == '0) begin
            last_col_idx_nxt = '0;
          end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
            last_col_idx_nxt = CW'(MAX_WIDTH - 1);
          end else begin
            last_col_idx_nxt = CW'(cfg_width - 1'b1);
          end
        end
        c420ds_pkg::REG_IMAGE_HEIGHT: begin
          if (cfg_height == '0) begin
            last_row_idx_nxt = '0;
          end else if (32'(cfg_height) > 32'(MAX_HEIGHT)) begin
            last_row_idx_nxt = RW'(MAX_HEIGHT - 1);
          end else begin
            last_row_idx_nxt = RW'(cfg_height - 1'b1);
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake
  // ---------------------------------------------------------------------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_ready;
  logic s1_adv;
  logic in_accept;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: position, pair sums, line store access
  // ---------------------------------------------------------------------------
  logic [CW-1:0] col_cnt_r, col_cnt_nxt;
  logic [RW-1:0] row_cnt_r, row_cnt_nxt;
  logic [2*c420ds_pkg::PIX_W-1:0] held_left_r, held_left_nxt;

  logic          last_col;
  logic          last_row;
  logic          odd_col;
  logic          odd_row;
  logic          pair_done;
  logic [CW-1:0] col_half;
  logic [LW-1:0] line_idx;
  logic          line_wr;
  c420ds_pkg::pair_sum_t    pair_sum;
  c420ds_pkg::chroma_kind_t kind_a;

  assign last_col  = (col_cnt_r == last_col_idx_r);
  assign last_row  = (row_cnt_r == last_row_idx_r);
  assign odd_col   = col_cnt_r[0];
  assign odd_row   = row_cnt_r[0];
  assign pair_done = odd_col || last_col;
  assign col_half  = col_cnt_r >> 1;

  // Wrap the line index when the half column reaches the store depth.
  always_comb begin
    if (col_half >= CW'(LINE_DEPTH)) begin
      line_idx = LW'(col_half - CW'(LINE_DEPTH));
    end else begin
      line_idx = LW'(col_half);
    end
  end

  always_comb begin
    if (odd_col) begin
      pair_sum.u = c420ds_pkg::SUM_W'(held_left_r[c420ds_pkg::PIX_W-1:0])
                 + c420ds_pkg::SUM_W'(in_u_sample);
      pair_sum.v = c420ds_pkg::SUM_W'(held_left_r[2*c420ds_pkg::PIX_W-1:c420ds_pkg::PIX_W])
                 + c420ds_pkg::SUM_W'(in_v_sample);
    end else begin
      pair_sum.u = c420ds_pkg::SUM_W'(in_u_sample);
      pair_sum.v = c420ds_pkg::SUM_W'(in_v_sample);
    end
  end

  always_comb begin
    kind_a  = c420ds_pkg::KIND_NONE;
    line_wr = 1'b0;
    if (pair_done) begin
      if (!odd_row) begin
        if (!last_row) begin
          line_wr = 1'b1;
        end else if (!odd_col) begin
          kind_a = c420ds_pkg::KIND_PASS;
        end else begin
          kind_a = c420ds_pkg::KIND_PAIR;
        end
      end else if (!odd_col) begin
        kind_a = c420ds_pkg::KIND_VERT;
      end else begin
        kind_a = c420ds_pkg::KIND_QUAD;
      end
    end
  end

  always_comb begin
    col_cnt_nxt   = col_cnt_r;
    row_cnt_nxt   = row_cnt_r;
    held_left_nxt = held_left_r;
    if (cfg_wr_en) begin
      // any register write restarts the image
      col_cnt_nxt = '0;
      row_cnt_nxt = '0;
    end else if (in_accept) begin
      if (!pair_done) begin
        held_left_nxt = {in_v_sample, in_u_sample};
      end
      if (last_col) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = last_row ? '0 : row_cnt_r + 1'b1;
      end else begin
        col_cnt_nxt = col_cnt_r + 1'b1;
      end
    end
  end

  // Line store of even-row pair sums; read data registered on accept.
  c420ds_pkg::pair_sum_t line_mem [LINE_DEPTH];
  c420ds_pkg::pair_sum_t line_rd_r;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (line_wr) begin
        line_mem[line_idx] <= pair_sum;
      end
      line_rd_r <= line_mem[line_idx];
    end
  end

  // Stage 1 payload
  logic [c420ds_pkg::PIX_W-1:0]  s1_y_r;
  c420ds_pkg::pair_sum_t         s1_sum_r;
  c420ds_pkg::chroma_kind_t      s1_kind_r;
  logic [c420ds_pkg::CCOL_W-1:0] s1_col_r;
  logic [c420ds_pkg::CROW_W-1:0] s1_row_r;
  logic                          s1_eoi_r;
  logic [RW-1:0]                 row_half;

  assign row_half = row_cnt_r >> 1;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_y_r    <= in_y_sample;
      s1_sum_r  <= pair_sum;
      s1_kind_r <= kind_a;
      s1_col_r  <= c420ds_pkg::CCOL_W'(col_half);
      s1_row_r  <= c420ds_pkg::CROW_W'(row_half);
      s1_eoi_r  <= last_col && last_row;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: averaging into the output register
  // ---------------------------------------------------------------------------
  logic [c420ds_pkg::TOT_W-1:0] tot_u;
  logic [c420ds_pkg::TOT_W-1:0] tot_v;
  logic [c420ds_pkg::TOT_W-1:0] pair_u_rnd;
  logic [c420ds_pkg::TOT_W-1:0] pair_v_rnd;
  logic [c420ds_pkg::PIX_W-1:0] chroma_u_b;
  logic [c420ds_pkg::PIX_W-1:0] chroma_v_b;
  logic                         chroma_valid_b;

  assign tot_u = c420ds_pkg::TOT_W'(s1_sum_r.u) + c420ds_pkg::TOT_W'(line_rd_r.u);
  assign tot_v = c420ds_pkg::TOT_W'(s1_sum_r.v) + c420ds_pkg::TOT_W'(line_rd_r.v);
  assign pair_u_rnd = c420ds_pkg::TOT_W'(s1_sum_r.u) + 1'b1;
  assign pair_v_rnd = c420ds_pkg::TOT_W'(s1_sum_r.v) + 1'b1;

  always_comb begin
    logic [c420ds_pkg::TOT_W-1:0] rnd_u;
    logic [c420ds_pkg::TOT_W-1:0] rnd_v;
    rnd_u          = '0;
    rnd_v          = '0;
    chroma_u_b     = '0;
    chroma_v_b     = '0;
    chroma_valid_b = 1'b1;
    unique case (s1_kind_r)
      c420ds_pkg::KIND_PASS: begin
        chroma_u_b = s1_sum_r.u[c420ds_pkg::PIX_W-1:0];
        chroma_v_b = s1_sum_r.v[c420ds_pkg::PIX_W-1:0];
      end
      c420ds_pkg::KIND_PAIR: begin
        chroma_u_b = pair_u_rnd[c420ds_pkg::PIX_W:1];
        chroma_v_b = pair_v_rnd[c420ds_pkg::PIX_W:1];
      end
      c420ds_pkg::KIND_VERT: begin
        rnd_u      = tot_u + 1'b1;
        rnd_v      = tot_v + 1'b1;
        chroma_u_b = rnd_u[c420ds_pkg::PIX_W:1];
        chroma_v_b = rnd_v[c420ds_pkg::PIX_W:1];
      end
      c420ds_pkg::KIND_QUAD: begin
        rnd_u      = tot_u + 2'd2;
        rnd_v      = tot_v + 2'd2;
        chroma_u_b = rnd_u[c420ds_pkg::PIX_W+1:2];
        chroma_v_b = rnd_v[c420ds_pkg::PIX_W+1:2];
      end
      default: begin
        chroma_valid_b = 1'b0;
      end
    endcase
  end

  logic [c420ds_pkg::PIX_W-1:0]  out_luma_r;
  logic                          out_chroma_valid_r;
  logic [c420ds_pkg::PIX_W-1:0]  out_chroma_u_r;
  logic [c420ds_pkg::PIX_W-1:0]  out_chroma_v_r;
  logic [c420ds_pkg::CCOL_W-1:0] out_chroma_col_r;
  logic [c420ds_pkg::CROW_W-1:0] out_chroma_row_r;
  logic                          out_end_of_image_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_luma_r         <= s1_y_r;
      out_chroma_valid_r <= chroma_valid_b;
      out_chroma_u_r     <= chroma_u_b;
      out_chroma_v_r     <= chroma_v_b;
      out_chroma_col_r   <= chroma_valid_b ? s1_col_r : '0;
      out_chroma_row_r   <= chroma_valid_b ? s1_row_r : '0;
      out_end_of_image_r <= s1_eoi_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_idx_r <= '0;
      last_row_idx_r <= '0;
      col_cnt_r      <= '0;
      row_cnt_r      <= '0;
      held_left_r    <= '0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      last_col_idx_r <= last_col_idx_nxt;
      last_row_idx_r <= last_row_idx_nxt;
      col_cnt_r      <= col_cnt_nxt;
      row_cnt_r      <= row_cnt_nxt;
      held_left_r    <= held_left_nxt;
      s1_valid_r     <= s1_valid_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_luma         = out_luma_r;
  assign out_chroma_valid = out_chroma_valid_r;
  assign out_chroma_u     = out_chroma_u_r;
  assign out_chroma_v     = out_chroma_v_r;
  assign out_chroma_col   = out_chroma_col_r;
  assign out_chroma_row   = out_chroma_row_r;
  assign out_end_of_image = out_end_of_image_r;

endmodule
